// File: rtl/mfd_pkg.sv
// shared types and constants of the message frame deframer
package mfd_pkg;

	// frame header layout
	localparam int unsigned HEADER_BYTES = 9;
	localparam int unsigned HDR_CNT_W    = 4;
	localparam logic [7:0]  TYPE_DATA    = 8'hFF;
	localparam logic [7:0]  TYPE_END     = 8'h00;

	// register reset values
	localparam logic [31:0] MAX_LEN_RESET = 32'h0001_0000;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_LEN  = 2'd0;
	localparam logic [1:0] REG_TOO_LONG = 2'd1;
	localparam logic [1:0] REG_BAD_TYPE = 2'd2;

	// error action codes (any other code shuts down)
	localparam logic [1:0] ACT_DROP   = 2'd0;
	localparam logic [1:0] ACT_REPORT = 2'd1;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_SKIP    = 2'd2,
		PH_STOP    = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_BYTE     = 3'd0,
		KIND_EMPTY    = 3'd1,
		KIND_EOS      = 3'd2,
		KIND_TOO_LONG = 3'd3,
		KIND_BAD_TYPE = 3'd4,
		KIND_SHUTDOWN = 3'd5
	} kind_t;

	typedef struct packed {
		logic [31:0] max_len;
		logic [1:0]  too_long_act;
		logic [1:0]  bad_type_act;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  data;
		logic        last;
		logic [63:0] length;
	} result_t;

endpackage

// File: rtl/mfd_parser.sv
// frame parser: header accumulation, payload counting and error actions
module mfd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  mfd_pkg::cfg_t    cfg,
	output mfd_pkg::result_t res
);
	import mfd_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [HDR_CNT_W-1:0]   hdr_cnt_q, hdr_cnt_d;
	logic [7:0]             type_q, type_d;
	logic [63:0]            accum_q, accum_d;
	logic [63:0]            left_q, left_d;

	logic        hdr_last;
	logic        too_long;
	logic        type_known;
	logic        err;
	logic [1:0]  act;
	logic        accum_zero;
	logic        left_one;
	logic        left_zero;

	// shared decode of the completing header
	assign hdr_last   = (hdr_cnt_q == HDR_CNT_W'(HEADER_BYTES - 1));
	assign too_long   = (accum_d[63:32] != 32'd0) || (accum_d[31:0] > cfg.max_len);
	assign type_known = (type_q == TYPE_END) || (type_q == TYPE_DATA);
	assign err        = too_long || !type_known;
	assign act        = too_long ? cfg.too_long_act : cfg.bad_type_act;
	assign accum_zero = (accum_d == 64'd0);
	assign left_one   = (left_q == 64'd1);
	assign left_zero  = (left_q == 64'd0);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_PAYLOAD: begin
				if (left_one) phase_d = PH_HEADER;
			end
			PH_SKIP: begin
				if (left_one || left_zero) phase_d = PH_HEADER;
			end
			PH_HEADER: begin
				if (hdr_last) begin
					if (err) begin
						if (act == ACT_DROP || act == ACT_REPORT) begin
							phase_d = accum_zero ? PH_HEADER : PH_SKIP;
						end else begin
							phase_d = PH_STOP;
						end
					end else if (type_q == TYPE_END) begin
						phase_d = PH_STOP;
					end else begin
						phase_d = accum_zero ? PH_HEADER : PH_PAYLOAD;
					end
				end
			end
			default: phase_d = phase_q;
		endcase
	end

	// counters and header fields
	always_comb begin
		hdr_cnt_d = hdr_cnt_q;
		type_d    = type_q;
		accum_d   = accum_q;
		left_d    = left_q;
		case (phase_q)
			PH_PAYLOAD: left_d = left_q - 64'd1;
			PH_SKIP: begin
				if (!left_zero) left_d = left_q - 64'd1;
			end
			PH_HEADER: begin
				if (hdr_cnt_q == '0) begin
					type_d    = rx_byte;
					accum_d   = 64'd0;
					hdr_cnt_d = HDR_CNT_W'(1);
				end else begin
					accum_d = {accum_q[55:0], rx_byte};
					if (hdr_last) begin
						hdr_cnt_d = '0;
						left_d    = accum_d;
					end else begin
						hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// result of this beat
	always_comb begin
		res.valid  = 1'b0;
		res.kind   = KIND_BYTE;
		res.data   = 8'd0;
		res.last   = 1'b0;
		res.length = accum_d;
		case (phase_q)
			PH_PAYLOAD: begin
				res.valid = 1'b1;
				res.data  = rx_byte;
				res.last  = left_one;
			end
			PH_HEADER: begin
				if (hdr_last) begin
					if (err) begin
						if (act == ACT_REPORT) begin
							res.valid = 1'b1;
							res.kind  = too_long ? KIND_TOO_LONG : KIND_BAD_TYPE;
						end else if (act != ACT_DROP) begin
							res.valid = 1'b1;
							res.kind  = KIND_SHUTDOWN;
						end
					end else if (type_q == TYPE_END) begin
						res.valid = 1'b1;
						res.kind  = KIND_EOS;
					end else if (accum_zero) begin
						res.valid = 1'b1;
						res.kind  = KIND_EMPTY;
					end
				end
			end
			default: ;
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			type_q    <= 8'd0;
			accum_q   <= 64'd0;
			left_q    <= 64'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			type_q    <= type_d;
			accum_q   <= accum_d;
			left_q    <= left_d;
		end
	end

endmodule

// File: rtl/message_frame_deframer.sv
// top level of the length-prefixed message frame deframer
//
// channel   direction  handshake            payload
// in        sink       in_valid / in_stall   rx_byte
// out       source     out_valid / out_stall result_kind, payload_byte,
//                                            last_of_message, frame_length
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one byte per cycle sustained while out_stall is low; each byte is held in
// the input register, then the parser step and result register take it.
// in_stall follows out_stall combinationally once the input and result
// registers are both full.
// reset puts the parser in header phase and the config registers at their defaults.
module message_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic        last_of_message,
	output logic [63:0] frame_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import mfd_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res;
	logic        s2_free;
	logic        step;
	logic        in_take;

	// handshake
	assign s2_free   = !valid_s2 || !out_stall;
	assign step      = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_len      <= MAX_LEN_RESET;
			cfg_q.too_long_act <= ACT_DROP;
			cfg_q.bad_type_act <= ACT_DROP;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_LEN:  cfg_q.max_len      <= cfg_data;
				REG_TOO_LONG: cfg_q.too_long_act <= cfg_data[1:0];
				REG_BAD_TYPE: cfg_q.bad_type_act <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser step
	mfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= res.valid;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign result_kind     = res_s2.kind;
	assign payload_byte    = res_s2.data;
	assign last_of_message = res_s2.last;
	assign frame_length    = res_s2.length;

endmodule
